@@ rtl/core/mpq_pkg.sv @@
`default_nettype none

package mpq_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int LIMIT_W         = 6;
	localparam int QCNT_W          = 6;
	localparam logic [LIMIT_W-1:0] KEEP_LIMIT_RST = 6'd60;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam int HDR_LEFT   = 0;
	localparam int HDR_RIGHT  = 1;
	localparam int HDR_MIDDLE = 2;
	localparam int HDR_SYNC   = 3;
	localparam int HDR_XSIGN  = 4;
	localparam int HDR_YSIGN  = 5;
	localparam int HDR_XOVF   = 6;
	localparam int HDR_YOVF   = 7;

	typedef enum logic [1:0] {
		FR_HEADER = 2'd0,
		FR_FIRST  = 2'd1,
		FR_LAST   = 2'd2
	} frame_state_t;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_READ = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		logic [2:0] buttons;
		logic [8:0] dy;
		logic [8:0] dx;
	} pkt_t;

	typedef struct packed {
		cmd_kind_t kind;
		pkt_t      pkt;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/mpq_in_if.sv @@
`default_nettype none

interface mpq_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mpq_out_if.sv @@
`default_nettype none

interface mpq_out_if;
	logic              valid;
	logic              ready;
	logic              packet_valid;
	logic signed [8:0] delta_x;
	logic signed [8:0] delta_y;
	logic [2:0]        buttons;
	logic [5:0]        queue_count;

	modport source (output valid, output packet_valid, output delta_x, output delta_y,
		output buttons, output queue_count, input ready);
	modport sink   (input valid, input packet_valid, input delta_x, input delta_y,
		input buttons, input queue_count, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mpq_ram.sv @@
`default_nettype none

module mpq_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/mpq_front.sv @@
`default_nettype none

module mpq_front (
	input  wire logic      clk,
	input  wire logic      arst_n,
	mpq_in_if.sink         req,
	output logic           cmd_valid,
	input  wire logic      cmd_ready,
	output mpq_pkg::cmd_t  cmd
);

	mpq_pkg::frame_state_t phase_q, phase_d;
	logic [7:0] header_q;
	logic [7:0] first_q;
	logic       fire;
	logic       ovf;
	logic [8:0] dx_raw;
	logic [8:0] dy_raw;

	assign req.ready = cmd_ready;
	assign fire      = req.valid && req.ready;

	always_comb begin
		phase_d = phase_q;
		if (fire && req.operation == mpq_pkg::OP_BYTE) begin
			case (phase_q)
				mpq_pkg::FR_FIRST: phase_d = mpq_pkg::FR_LAST;
				mpq_pkg::FR_LAST:  phase_d = mpq_pkg::FR_HEADER;
				default: begin
					phase_d = req.rx_byte[mpq_pkg::HDR_SYNC] ? mpq_pkg::FR_FIRST
						: mpq_pkg::FR_HEADER;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mpq_pkg::FR_HEADER;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && req.operation == mpq_pkg::OP_BYTE) begin
			if (phase_q == mpq_pkg::FR_FIRST) begin
				first_q <= req.rx_byte;
			end else if (phase_q != mpq_pkg::FR_LAST && req.rx_byte[mpq_pkg::HDR_SYNC]) begin
				header_q <= req.rx_byte;
			end
		end
	end

	// zero magnitude with sign set stays zero
	assign dx_raw = {header_q[mpq_pkg::HDR_XSIGN] && (first_q != 8'd0), first_q};
	assign dy_raw = {header_q[mpq_pkg::HDR_YSIGN] && (req.rx_byte != 8'd0), req.rx_byte};
	assign ovf    = header_q[mpq_pkg::HDR_XOVF] || header_q[mpq_pkg::HDR_YOVF];

	always_comb begin
		cmd_valid = req.valid
			&& (req.operation == mpq_pkg::OP_READ || phase_q == mpq_pkg::FR_LAST);
		cmd.kind  = (req.operation == mpq_pkg::OP_READ) ? mpq_pkg::CMD_READ
			: mpq_pkg::CMD_PUSH;
		cmd.pkt.dx = ovf ? 9'd0 : dx_raw;
		cmd.pkt.dy = ovf ? 9'd0 : 9'(9'd0 - dy_raw);
		cmd.pkt.buttons = {header_q[mpq_pkg::HDR_MIDDLE], header_q[mpq_pkg::HDR_RIGHT],
			header_q[mpq_pkg::HDR_LEFT]};
	end

endmodule

`default_nettype wire

@@ rtl/core/mpq_cmd_fifo.sv @@
`default_nettype none

module mpq_cmd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire mpq_pkg::cmd_t  push_cmd,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output mpq_pkg::cmd_t       pop_cmd
);

	mpq_pkg::cmd_t ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_cmd    = ent_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/mpq_back.sv @@
`default_nettype none

module mpq_back #(
	parameter int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [mpq_pkg::LIMIT_W-1:0] cfg_wdata,
	input  wire logic                        cmd_valid,
	output logic                             cmd_ready,
	input  wire mpq_pkg::cmd_t               cmd,
	mpq_out_if.source                        rsp
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int MW = (CW > mpq_pkg::LIMIT_W) ? CW : mpq_pkg::LIMIT_W;

	logic [mpq_pkg::LIMIT_W-1:0] limit_q;
	logic [PW-1:0] rp_q;
	logic [PW-1:0] wp_q;
	logic [CW-1:0] count_q;

	logic          cmd_fire;
	logic          is_push;
	logic          is_read;
	logic          nonempty;
	logic          rd_fire;
	logic [MW-1:0] keep_m;
	logic [CW-1:0] drop;
	logic [SW-1:0] rp_sum;
	logic [PW-1:0] rp_push;
	logic [PW-1:0] rp_inc;
	logic [PW-1:0] wp_inc;
	logic [CW-1:0] count_push;

	logic                       valid_s1;
	logic                       pkt_valid_s1;
	logic [mpq_pkg::QCNT_W-1:0] qcount_s1;
	mpq_pkg::pkt_t              rd_pkt;

	assign is_read   = (cmd.kind == mpq_pkg::CMD_READ);
	assign is_push   = (cmd.kind == mpq_pkg::CMD_PUSH);
	assign nonempty  = (count_q != '0);
	assign cmd_ready = is_push || !valid_s1 || rsp.ready;
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign rd_fire   = cmd_fire && is_read;

	// trim to the keep limit and to one below full, then push
	always_comb begin
		keep_m = MW'(count_q);
		if (keep_m > MW'(limit_q)) begin
			keep_m = MW'(limit_q);
		end
		if (keep_m > MW'(QUEUE_DEPTH - 1)) begin
			keep_m = MW'(QUEUE_DEPTH - 1);
		end
		drop   = CW'(MW'(count_q) - keep_m);
		rp_sum = SW'(rp_q) + SW'(drop);
		if (rp_sum >= SW'(QUEUE_DEPTH)) begin
			rp_sum = rp_sum - SW'(QUEUE_DEPTH);
		end
		rp_push    = PW'(rp_sum);
		count_push = CW'(keep_m) + CW'(1);
	end

	assign rp_inc = (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PW'(1);
	assign wp_inc = (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= mpq_pkg::KEEP_LIMIT_RST;
			rp_q     <= '0;
			wp_q     <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd_fire && is_push) begin
				rp_q    <= rp_push;
				wp_q    <= wp_inc;
				count_q <= count_push;
			end else if (rd_fire && nonempty) begin
				rp_q    <= rp_inc;
				count_q <= count_q - CW'(1);
			end
			if (rd_fire) begin
				valid_s1 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_fire) begin
			pkt_valid_s1 <= nonempty;
			qcount_s1    <= nonempty ? mpq_pkg::QCNT_W'(count_q - CW'(1)) : '0;
		end
	end

	mpq_ram #(
		.WIDTH ($bits(mpq_pkg::pkt_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd_fire && is_push),
		.waddr (wp_q),
		.wdata (cmd.pkt),
		.re    (rd_fire && nonempty),
		.raddr (rp_q),
		.rdata (rd_pkt)
	);

	assign rsp.valid        = valid_s1;
	assign rsp.packet_valid = pkt_valid_s1;
	assign rsp.delta_x      = pkt_valid_s1 ? signed'(rd_pkt.dx) : '0;
	assign rsp.delta_y      = pkt_valid_s1 ? signed'(rd_pkt.dy) : '0;
	assign rsp.buttons      = pkt_valid_s1 ? rd_pkt.buttons : '0;
	assign rsp.queue_count  = qcount_s1;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("packet count above depth");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(SW'(rp_q) + SW'(count_q) == SW'(wp_q))
		|| (SW'(rp_q) + SW'(count_q) == SW'(wp_q) + SW'(QUEUE_DEPTH)))
		else $error("pointers and count disagree");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		rd_fire && nonempty |=> count_q == $past(count_q) - CW'(1))
		else $error("pop did not decrement count");

	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !pkt_valid_s1 |-> qcount_s1 == '0)
		else $error("empty read reports nonzero count");
`endif

endmodule

`default_nettype wire

@@ rtl/core/ps2_mouse_packet_queue.sv @@
`default_nettype none

// PS/2 mouse packet queue. The req channel takes one beat per cycle while ready:
// a received mouse byte (operation 0) or a read request (operation 1). Bytes are
// framed into three-byte packets, headers without bit 3 are dropped, and each
// finished packet is pushed into a QUEUE_DEPTH-entry RAM ring, trimming the oldest
// entries to keep_limit first. Each read returns one rsp beat via the two-entry
// command queue and the registered RAM read; sustained rate is one beat per cycle
// while rsp is ready, set by the single RAM access per command. A stalled rsp backs
// up through the command queue into req.ready. The user must write keep_limit
// through cfg_we/cfg_wdata only while idle; the block itself does not enforce this. No clearing pass after reset.
module ps2_mouse_packet_queue #(
	parameter int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	mpq_in_if.sink                           req,
	mpq_out_if.source                        rsp,
	input  wire logic                        cfg_we,
	input  wire logic [mpq_pkg::LIMIT_W-1:0] cfg_wdata
);

	logic          f_valid;
	logic          f_ready;
	mpq_pkg::cmd_t f_cmd;
	logic          b_valid;
	logic          b_ready;
	mpq_pkg::cmd_t b_cmd;

	mpq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	mpq_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_cmd   (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_cmd    (b_cmd)
	);

	mpq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd       (b_cmd),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
